>>> rtl/pdtm_pkg.sv
// Shared types and constants for the PWM duty and tachometer meter.
package pdtm_pkg;

	// Event codes carried in the operation field.
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_CAPTURE = 2'd1;
	localparam logic [1:0] OP_TACH    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_COUNTER_MODULO = 2'd0;
	localparam logic [1:0] REG_WINDOW_TICKS   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;
	localparam logic [1:0] REG_RPM_PER_PULSE  = 2'd3;

	localparam logic [15:0] COUNTER_MODULO_RST = 16'd16000;
	localparam logic [15:0] WINDOW_TICKS_RST   = 16'd250;
	localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd500;
	localparam logic [7:0]  RPM_PER_PULSE_RST  = 8'd60;

	localparam logic [13:0] DUTY_SCALE   = 14'd10000;
	localparam logic [13:0] TEMP_OFFSET  = 14'd3200;
	localparam logic [17:0] TEMP_DIVISOR = 18'd47;
	// Temperature for a duty of zero: -32000/47 truncated, i.e. -680.
	localparam logic [11:0] TEMP_RST     = 12'hD58;

	// The divider produces one quotient bit per cycle.
	localparam int unsigned DIV_STEPS = 14;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] capture_value;
	} pdtm_in_t;

	typedef struct packed {
		logic [13:0]        duty_hundredths;
		logic signed [11:0] temperature_tenths;
		logic [15:0]        fan_rpm;
		logic               duty_updated;
		logic               pulses_updated;
	} pdtm_out_t;

	typedef struct packed {
		logic ev;
		logic div_load_duty;
		logic div_load_temp;
		logic div_step;
		logic duty_wr;
		logic temp_wr;
		logic out_load;
	} pdtm_cmd_t;

	typedef struct packed {
		logic duty_finish;
	} pdtm_status_t;

endpackage

>>> rtl/pdtm_dp.sv
// Datapath: event state, configuration registers, shared divider and result register.
module pdtm_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdtm_pkg::pdtm_in_t    in_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [15:0]           cfg_wdata,
	input  pdtm_pkg::pdtm_cmd_t   cmd,
	output pdtm_pkg::pdtm_status_t st,
	output pdtm_pkg::pdtm_out_t   out_data
);
	import pdtm_pkg::*;

	localparam logic [1:0] DPH_FALL  = 2'd1;
	localparam logic [1:0] DPH_RISE2 = 2'd2;

	logic [15:0] counter_modulo_q, window_ticks_q, timeout_ticks_q;
	logic [7:0]  rpm_per_pulse_q;

	logic [31:0] tick_count_q, window_start_q, timeout_start_q;
	logic [1:0]  duty_phase_q;
	logic [15:0] first_edge_q, second_edge_q;
	logic [16:0] pulse_width_q;
	logic [13:0] latest_duty_q;
	logic        count_phase_q, timeout_phase_q, edge_seen_q;
	logic [15:0] running_pulses_q, published_pulses_q;
	logic [11:0] temp_q;
	logic        temp_neg_q;
	logic        duty_upd_q, pulse_upd_q;

	logic [17:0] period_q;
	logic [30:0] num_q;

	logic [18:0] rem_q;
	logic [13:0] numlo_q, quo_q;
	logic [17:0] den_q;

	pdtm_out_t   out_q;

	logic [31:0] tick_next;
	logic        tmo_elapsed;
	logic        win_open;
	logic        pulse_upd_d;
	logic [18:0] div_trial;
	logic        div_ge;
	logic [13:0] temp_mag;
	logic [17:0] temp_num;
	logic [23:0] rpm_prod;
	logic [15:0] rpm_sat;

	function automatic logic [16:0] wrap_diff(input logic [15:0] from, input logic [15:0] to,
	                                          input logic [15:0] modulo);
		if (to >= from) begin
			return {1'b0, to} - {1'b0, from};
		end
		return {1'b0, modulo} - {1'b0, from} + {1'b0, to};
	endfunction

	assign st.duty_finish = (in_data.operation == OP_CAPTURE) && (duty_phase_q == DPH_RISE2);

	assign tick_next = tick_count_q + 32'd1;

	assign tmo_elapsed = (tick_next - timeout_start_q) >= {16'd0, timeout_ticks_q};
	assign win_open    = (tick_count_q - window_start_q) < {16'd0, window_ticks_q};

	// The count is published at a late tach edge, or cleared when a timeout passes with no edge.
	assign pulse_upd_d = ((in_data.operation == OP_TICK) && timeout_phase_q && tmo_elapsed
	                      && !edge_seen_q)
	                     || ((in_data.operation == OP_TACH) && count_phase_q && !win_open);

	assign div_trial = {rem_q[17:0], numlo_q[13]};
	assign div_ge    = div_trial >= {1'b0, den_q};

	always_comb begin
		if (latest_duty_q < TEMP_OFFSET) begin
			temp_mag = TEMP_OFFSET - latest_duty_q;
		end else begin
			temp_mag = latest_duty_q - TEMP_OFFSET;
		end
		temp_num = 18'({temp_mag, 3'b000}) + 18'({temp_mag, 1'b0});
	end

	assign rpm_prod = 24'(published_pulses_q) * 24'(rpm_per_pulse_q);
	assign rpm_sat  = (rpm_prod > 24'h00FFFF) ? 16'hFFFF : rpm_prod[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_modulo_q   <= COUNTER_MODULO_RST;
			window_ticks_q     <= WINDOW_TICKS_RST;
			timeout_ticks_q    <= TIMEOUT_TICKS_RST;
			rpm_per_pulse_q    <= RPM_PER_PULSE_RST;
			tick_count_q       <= '0;
			window_start_q     <= '0;
			timeout_start_q    <= '0;
			duty_phase_q       <= '0;
			first_edge_q       <= '0;
			second_edge_q      <= '0;
			pulse_width_q      <= '0;
			latest_duty_q      <= '0;
			count_phase_q      <= 1'b0;
			timeout_phase_q    <= 1'b0;
			edge_seen_q        <= 1'b0;
			running_pulses_q   <= '0;
			published_pulses_q <= '0;
			temp_q             <= TEMP_RST;
			temp_neg_q         <= 1'b0;
			duty_upd_q         <= 1'b0;
			pulse_upd_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_COUNTER_MODULO: counter_modulo_q <= cfg_wdata;
					REG_WINDOW_TICKS:   window_ticks_q   <= cfg_wdata;
					REG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg_wdata;
					REG_RPM_PER_PULSE:  rpm_per_pulse_q  <= cfg_wdata[7:0];
					default: ;
				endcase
			end

			if (cmd.ev) begin
				duty_upd_q  <= st.duty_finish;
				pulse_upd_q <= pulse_upd_d;
				unique case (in_data.operation)
					OP_TICK: begin
						tick_count_q <= tick_next;
						if (!timeout_phase_q) begin
							timeout_start_q <= tick_next;
							edge_seen_q     <= 1'b0;
							timeout_phase_q <= 1'b1;
						end else if (tmo_elapsed) begin
							if (!edge_seen_q) begin
								published_pulses_q <= '0;
								count_phase_q      <= 1'b0;
							end
							timeout_phase_q <= 1'b0;
						end
					end
					OP_CAPTURE: begin
						case (duty_phase_q) inside
							DPH_FALL: begin
								second_edge_q <= in_data.capture_value;
								pulse_width_q <= wrap_diff(first_edge_q, in_data.capture_value,
								                           counter_modulo_q);
								duty_phase_q  <= DPH_RISE2;
							end
							DPH_RISE2: begin
								duty_phase_q <= '0;
							end
							default: begin
								first_edge_q <= in_data.capture_value;
								duty_phase_q <= DPH_FALL;
							end
						endcase
					end
					OP_TACH: begin
						edge_seen_q <= 1'b1;
						if (!count_phase_q) begin
							window_start_q   <= tick_count_q;
							running_pulses_q <= '0;
							count_phase_q    <= 1'b1;
						end else if (win_open) begin
							if (running_pulses_q != 16'hFFFF) begin
								running_pulses_q <= running_pulses_q + 16'd1;
							end
						end else begin
							published_pulses_q <= running_pulses_q;
							count_phase_q      <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			// A zero period gives a duty of zero; the divider result is then ignored.
			if (cmd.duty_wr) begin
				latest_duty_q <= (period_q == '0) ? '0 : quo_q;
			end
			if (cmd.div_load_temp) begin
				temp_neg_q <= latest_duty_q < TEMP_OFFSET;
			end
			if (cmd.temp_wr) begin
				temp_q <= temp_neg_q ? 12'(-quo_q[11:0]) : quo_q[11:0];
			end
		end
	end

	// Operands for the duty division, captured with the closing rise.
	always_ff @(posedge clk) begin
		if (cmd.ev && st.duty_finish) begin
			period_q <= 18'(wrap_diff(second_edge_q, in_data.capture_value, counter_modulo_q))
			            + 18'(pulse_width_q);
			num_q    <= 31'(pulse_width_q) * 31'(DUTY_SCALE);
		end
	end

	// Restoring divider. The dividend is always below the divisor times 2^14,
	// so fourteen steps give the whole quotient.
	always_ff @(posedge clk) begin
		if (cmd.div_load_duty) begin
			rem_q   <= {2'b00, num_q[30:14]};
			numlo_q <= num_q[13:0];
			quo_q   <= '0;
			den_q   <= period_q;
		end else if (cmd.div_load_temp) begin
			rem_q   <= {15'd0, temp_num[17:14]};
			numlo_q <= temp_num[13:0];
			quo_q   <= '0;
			den_q   <= TEMP_DIVISOR;
		end else if (cmd.div_step) begin
			rem_q   <= div_ge ? (div_trial - {1'b0, den_q}) : div_trial;
			numlo_q <= {numlo_q[12:0], 1'b0};
			quo_q   <= {quo_q[12:0], div_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.duty_hundredths    <= latest_duty_q;
			out_q.temperature_tenths <= temp_q;
			out_q.fan_rpm            <= rpm_sat;
			out_q.duty_updated       <= duty_upd_q;
			out_q.pulses_updated     <= pulse_upd_q;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/pdtm_ctrl.sv
// Controller: sequences event update, the two divisions and the hand-off of the result.
module pdtm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pdtm_pkg::pdtm_status_t st,
	output pdtm_pkg::pdtm_cmd_t    cmd
);
	import pdtm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DLOAD = 3'd1;
	localparam logic [2:0] S_DDIV  = 3'd2;
	localparam logic [2:0] S_DWR   = 3'd3;
	localparam logic [2:0] S_TLOAD = 3'd4;
	localparam logic [2:0] S_TDIV  = 3'd5;
	localparam logic [2:0] S_TWR   = 3'd6;
	localparam logic [2:0] S_PUB   = 3'd7;

	localparam logic [3:0] STEP_LAST = 4'(DIV_STEPS - 1);

	logic [2:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ev  = 1'b1;
					state_d = st.duty_finish ? S_DLOAD : S_PUB;
				end
			end
			S_DLOAD: begin
				cmd.div_load_duty = 1'b1;
				cnt_d   = STEP_LAST;
				state_d = S_DDIV;
			end
			S_DDIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 4'd1;
				if (cnt_q == '0) begin
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				cmd.duty_wr = 1'b1;
				state_d = S_TLOAD;
			end
			S_TLOAD: begin
				cmd.div_load_temp = 1'b1;
				cnt_d   = STEP_LAST;
				state_d = S_TDIV;
			end
			S_TDIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 4'd1;
				if (cnt_q == '0) begin
					state_d = S_TWR;
				end
			end
			S_TWR: begin
				cmd.temp_wr = 1'b1;
				state_d = S_PUB;
			end
			S_PUB: begin
				// Wait here until the result register is free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_plain_event_to_pub: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !st.duty_finish) |=> (state_q == S_PUB))
		else $error("event without duty result did not go straight to publish");

	a_duty_event_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && st.duty_finish) |=> (state_q == S_DLOAD))
		else $error("closing capture did not start the duty division");

	a_step_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DDIV || state_q == S_TDIV) |-> (cnt_q <= STEP_LAST))
		else $error("divider step count out of range");

	a_valid_rises_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result valid raised without a load");

endmodule

>>> rtl/pwm_duty_and_tacho_meter.sv
// Top level of the PWM duty meter and tachometer: controller plus datapath.
// Ticks, tach edges, opening captures and unused codes go from the event update straight to publishing.
// A capture that closes a period first captures the operands, then makes two passes of the
// shared 14-step divider (duty, then temperature) with a load and a write-back around each.
// One request is in work at a time; the next is taken while the previous result waits.
// Asynchronous active-low reset: registers to their listed defaults, event state cleared.
module pwm_duty_and_tacho_meter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdtm_pkg::pdtm_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pdtm_pkg::pdtm_out_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata
);
	import pdtm_pkg::*;

	pdtm_cmd_t    cmd;
	pdtm_status_t st;

	pdtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	pdtm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
